// ===== sv/sflg_pkg.sv =====
// Shared types and constants for the sparse facility-location gain block.
`timescale 1ns / 1ps
`default_nettype none

package sflg_pkg;

	localparam int OPCODE_W = 2;
	localparam int INDEX_W  = 10;
	localparam int WEIGHT_W = 16;
	localparam int ROW_W    = 22;
	localparam int TOTAL_W  = 26;

	localparam int NUM_POINTS_DEF  = 1024;
	localparam int WEIGHT_BITS_DEF = 16;

	typedef enum logic [OPCODE_W-1:0] {
		OP_GAIN  = 2'd0,
		OP_ADD   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'd0,
		ST_IDLE  = 2'd1,
		ST_EXEC  = 2'd2
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;    // capture input word, read table
		logic exec;      // update state, load result register
		logic clr_step;  // write one zero entry of the sweep
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;  // sweep is at the final entry
		logic out_free;  // result register can take a word this cycle
		logic op_clear;  // captured word is a clear
	} ctrl_sts_t;

endpackage

`default_nettype wire

// ===== sv/sflg_if.sv =====
// Valid/ready channel interfaces for input and result words.
`timescale 1ns / 1ps
`default_nettype none

interface sflg_in_if;
	logic                          valid;
	logic                          ready;
	logic [sflg_pkg::OPCODE_W-1:0] opcode;
	logic [sflg_pkg::INDEX_W-1:0]  neighbor_index;
	logic [sflg_pkg::WEIGHT_W-1:0] neighbor_weight;
	logic                          row_last;

	modport source (output valid, opcode, neighbor_index, neighbor_weight, row_last,
		input ready);
	modport sink (input valid, opcode, neighbor_index, neighbor_weight, row_last,
		output ready);
endinterface

interface sflg_out_if;
	logic                          valid;
	logic                          ready;
	logic [sflg_pkg::WEIGHT_W-1:0] pair_gain;
	logic [sflg_pkg::ROW_W-1:0]    row_gain;
	logic                          row_done;
	logic [sflg_pkg::TOTAL_W-1:0]  coverage_total;

	modport source (output valid, pair_gain, row_gain, row_done, coverage_total,
		input ready);
	modport sink (input valid, pair_gain, row_gain, row_done, coverage_total,
		output ready);
endinterface

`default_nettype wire

// ===== sv/sflg_ctrl.sv =====
// Controller state machine: clear sweep, word accept and update sequencing.
`timescale 1ns / 1ps
`default_nettype none

module sflg_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire sflg_pkg::ctrl_sts_t sts,
	output sflg_pkg::ctrl_cmd_t      cmd
);

	sflg_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sflg_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			sflg_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nxt = sflg_pkg::ST_IDLE;
				end
			end
			sflg_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				cmd.accept = item_valid;
				if (item_valid) begin
					state_nxt = sflg_pkg::ST_EXEC;
				end
			end
			sflg_pkg::ST_EXEC: begin
				if (sts.out_free) begin
					cmd.exec  = 1'b1;
					state_nxt = sts.op_clear ? sflg_pkg::ST_CLEAR : sflg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = sflg_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/sflg_dp.sv =====
// Datapath: best-coverage table, running total, row gain and result register.
`timescale 1ns / 1ps
`default_nettype none

module sflg_dp #(
	parameter int NUM_POINTS  = sflg_pkg::NUM_POINTS_DEF,
	parameter int WEIGHT_BITS = sflg_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sflg_pkg::ctrl_cmd_t           cmd,
	output sflg_pkg::ctrl_sts_t                sts,
	input  wire logic [sflg_pkg::OPCODE_W-1:0] opcode,
	input  wire logic [sflg_pkg::INDEX_W-1:0]  neighbor_index,
	input  wire logic [sflg_pkg::WEIGHT_W-1:0] neighbor_weight,
	input  wire logic                          row_last,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [sflg_pkg::WEIGHT_W-1:0]      pair_gain,
	output logic [sflg_pkg::ROW_W-1:0]         row_gain,
	output logic                               row_done,
	output logic [sflg_pkg::TOTAL_W-1:0]       coverage_total
);

	localparam int WW = sflg_pkg::WEIGHT_W;
	localparam int RW = sflg_pkg::ROW_W;
	localparam int TW = sflg_pkg::TOTAL_W;
	localparam int AW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
	localparam int XW = (AW > sflg_pkg::INDEX_W) ? AW : sflg_pkg::INDEX_W;
	// stored weight width: the field carries at most WW bits
	localparam int SW = (WEIGHT_BITS < WW) ? WEIGHT_BITS : WW;

	logic [SW-1:0] mem [NUM_POINTS];

	// captured word
	sflg_pkg::op_t op_q;
	logic [XW-1:0] idx_q;
	logic [WW-1:0] w_q;
	logic          last_q;
	logic          in_range_q;
	logic [SW-1:0] rdata_q;

	logic [AW-1:0] clr_cnt_q;
	logic [RW-1:0] acc_q;
	logic [TW-1:0] total_q;
	logic          out_valid_q;

	logic [XW-1:0] idx_in;
	logic [WW-1:0] w_in;
	logic [WW-1:0] best;
	logic [WW-1:0] gain;
	logic [RW:0]   row_sum;
	logic [RW-1:0] row_sat;
	logic [TW:0]   tot_sum;
	logic [TW-1:0] tot_sat;
	logic          add_wr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [SW-1:0] wdata;

	assign idx_in = XW'(neighbor_index);
	assign w_in   = WW'(neighbor_weight[SW-1:0]);

	// gain against stored best, out-of-range points read as zero
	assign best    = in_range_q ? WW'(rdata_q) : '0;
	assign gain    = (w_q > best) ? (w_q - best) : '0;
	assign row_sum = (RW+1)'(acc_q) + (RW+1)'(gain);
	assign row_sat = row_sum[RW] ? '1 : row_sum[RW-1:0];
	assign tot_sum = (TW+1)'(total_q) + (TW+1)'(gain);
	assign tot_sat = tot_sum[TW] ? '1 : tot_sum[TW-1:0];
	assign add_wr  = (op_q == sflg_pkg::OP_ADD) && in_range_q && (gain != '0);

	assign we    = cmd.clr_step || (cmd.exec && add_wr);
	assign waddr = cmd.clr_step ? clr_cnt_q : idx_q[AW-1:0];
	assign wdata = cmd.clr_step ? '0 : w_q[SW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.accept) begin
			rdata_q <= mem[idx_in[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q       <= sflg_pkg::op_t'(opcode);
			idx_q      <= idx_in;
			w_q        <= w_in;
			last_q     <= row_last;
			in_range_q <= (32'(neighbor_index) < 32'(NUM_POINTS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= sts.clr_last ? '0 : clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			total_q <= '0;
		end else if (cmd.exec) begin
			case (op_q)
				sflg_pkg::OP_GAIN, sflg_pkg::OP_ADD: begin
					acc_q <= last_q ? '0 : row_sat;
					if (add_wr) begin
						total_q <= tot_sat;
					end
				end
				sflg_pkg::OP_CLEAR: begin
					acc_q   <= '0;
					total_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			case (op_q)
				sflg_pkg::OP_GAIN, sflg_pkg::OP_ADD: begin
					pair_gain      <= gain;
					row_gain       <= row_sat;
					row_done       <= last_q;
					coverage_total <= add_wr ? tot_sat : total_q;
				end
				sflg_pkg::OP_CLEAR: begin
					pair_gain      <= '0;
					row_gain       <= '0;
					row_done       <= 1'b0;
					coverage_total <= '0;
				end
				default: begin
					pair_gain      <= '0;
					row_gain       <= acc_q;
					row_done       <= 1'b0;
					coverage_total <= total_q;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.clr_last = (clr_cnt_q == AW'(NUM_POINTS - 1));
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.op_clear = (op_q == sflg_pkg::OP_CLEAR);

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && cmd.clr_step))
		else $error("word accepted during table sweep");

	a_total_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_q != sflg_pkg::OP_CLEAR) |=> (total_q >= $past(total_q)))
		else $error("coverage total dropped without a clear");

	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && last_q && (op_q == sflg_pkg::OP_GAIN || op_q == sflg_pkg::OP_ADD))
		|=> (acc_q == '0))
		else $error("row gain not restarted after row end");

	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (gain <= w_q))
		else $error("pair gain exceeds weight");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_q == sflg_pkg::OP_CLEAR) |=> (total_q == '0 && clr_cnt_q == '0))
		else $error("clear left total or sweep counter nonzero");

endmodule

`default_nettype wire

// ===== sv/sparse_facility_location_gain.sv =====
// Top level of the sparse facility-location marginal gain engine.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//  item   : sink channel, one neighbor pair per word (opcode, neighbor_index,
//           neighbor_weight, row_last). Opcode gain or add scores the pair
//           against the best coverage stored for its point; add also raises
//           that best and the running total; clear zeroes all state.
//  result : source channel, exactly one word per input word, in order.
//  Order: the accept edge reads the table into a register; the update edge,
//           taken once the result register is free, loads the result word.
//  Pacing: a new word is taken only after the previous word's registered
//           table read and its update/write-back step have both completed.
//  Clear: a clear word returns its result, then the table is zeroed one entry
//           per cycle over the whole table; item.ready stays low meanwhile.
//  Reset: arst_n low clears control, total and row gain; after release the
//           same table sweep runs before the first word is taken.
//  Stall: the result register holds while result.ready is low; one more word
//           may be accepted and then waits in the update cycle until the
//           result register frees up.
//  Out-of-range indexes score against zero and never write the table.

module sparse_facility_location_gain #(
	parameter int NUM_POINTS  = sflg_pkg::NUM_POINTS_DEF,
	parameter int WEIGHT_BITS = sflg_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sflg_in_if.sink    item,
	sflg_out_if.source result
);

	sflg_pkg::ctrl_cmd_t cmd;
	sflg_pkg::ctrl_sts_t sts;
	logic                item_ready;

	sflg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	sflg_dp #(
		.NUM_POINTS  (NUM_POINTS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.opcode          (item.opcode),
		.neighbor_index  (item.neighbor_index),
		.neighbor_weight (item.neighbor_weight),
		.row_last        (item.row_last),
		.out_valid       (result.valid),
		.out_ready       (result.ready),
		.pair_gain       (result.pair_gain),
		.row_gain        (result.row_gain),
		.row_done        (result.row_done),
		.coverage_total  (result.coverage_total)
	);

	assign item.ready = item_ready;

endmodule

`default_nettype wire
